[sv/rlsm_pkg.sv]
// package for the radio link service monitor: field widths, operation codes,
// register indexes, reset values and statistic counter indexes
// no dependencies
package rlsm_pkg;

   localparam int STAT_WIDTH = 32;
   localparam int STAT_COUNT = 9;
   localparam int STAT_IDX_W = $clog2(STAT_COUNT);

   localparam int OP_W          = 3;
   localparam int LEN_W         = 8;
   localparam int NUM_W         = 16;
   localparam int SEL_W         = 4;
   localparam int STAT_VALUE_W  = 32;
   localparam int GAP_W         = 15;

   localparam int REQ_FIELDS_W  = LEN_W + NUM_W + SEL_W;
   localparam int REQ_DATA_W    = ((REQ_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_FIELDS_W  = 2 + NUM_W + STAT_VALUE_W + GAP_W;
   localparam int RSP_DATA_W    = ((RSP_FIELDS_W + 7) / 8) * 8;

   localparam int CSR_INDEX_W   = 3;
   localparam int CSR_DATA_W    = 16;

   typedef enum logic [OP_W-1:0] {
      OP_RX_GOOD        = 3'd0,
      OP_RX_BAD         = 3'd1,
      OP_RX_INCOMPLETE  = 3'd2,
      OP_LISTEN_TIMEOUT = 3'd3,
      OP_TX_FAIL        = 3'd4,
      OP_TX_STAMP       = 3'd5,
      OP_READ_STAT      = 3'd6
   } op_type;

   localparam logic [CSR_INDEX_W-1:0] CSR_HEADER_LENGTH    = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PAYLOAD_LIMIT    = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEEPALIVE_LENGTH = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEEPALIVE_NUMBER = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_LOSS_TIMEOUTS    = 3'd4;

   localparam logic [LEN_W-1:0] RST_HEADER_LENGTH    = 8'd2;
   localparam logic [LEN_W-1:0] RST_PAYLOAD_LIMIT    = 8'd64;
   localparam logic [LEN_W-1:0] RST_KEEPALIVE_LENGTH = 8'd2;
   localparam logic [NUM_W-1:0] RST_KEEPALIVE_NUMBER = 16'hFFFF;
   localparam logic [7:0]       RST_LOSS_TIMEOUTS    = 8'd8;

   localparam logic [STAT_IDX_W-1:0] IDX_LOST       = 4'd0;
   localparam logic [STAT_IDX_W-1:0] IDX_BURST_1    = 4'd1;
   localparam logic [STAT_IDX_W-1:0] IDX_BURST_2    = 4'd2;
   localparam logic [STAT_IDX_W-1:0] IDX_BURST_3_4  = 4'd3;
   localparam logic [STAT_IDX_W-1:0] IDX_BURST_5UP  = 4'd4;
   localparam logic [STAT_IDX_W-1:0] IDX_MAX        = 4'd5;
   localparam logic [STAT_IDX_W-1:0] IDX_OUTAGE     = 4'd6;
   localparam logic [STAT_IDX_W-1:0] IDX_INCOMPLETE = 4'd7;
   localparam logic [STAT_IDX_W-1:0] IDX_TXFAIL     = 4'd8;

endpackage

[sv/radio_link_service_monitor.sv]
// top level of the radio link service monitor: event register, update logic
// for link state and statistics, result register
// depends on rlsm_pkg
//
// One radio event is taken per clock cycle while the result side keeps up. An
// event is held in an input register; when the result register is free or
// being taken, the link state, the sequence tracking and the statistic counters
// are updated and the result is loaded into an output register. A stalled
// result holds the event stage; the event stage itself still takes one more
// event. All link state, statistics and configuration are reset at once, there
// is no clearing pass. Configuration writes are always taken and apply to events
// processed afterwards.
module radio_link_service_monitor (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // packet_length, packet_number, stat_select, zero pad
   input  logic [rlsm_pkg::REQ_DATA_W-1:0]     req_tdata,
   // operation
   input  logic [rlsm_pkg::OP_W-1:0]           req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // in_service, deliver_frame, stamp_number, stat_value, gap_found, zero pad
   output logic [rlsm_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [rlsm_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [rlsm_pkg::CSR_DATA_W-1:0]     csr_data
);
   import rlsm_pkg::*;

   function automatic logic [NUM_W-1:0] next_number(input logic [NUM_W-1:0] n,
                                                    input logic [NUM_W-1:0] ka);
      logic [NUM_W-1:0] n1;
      n1 = n + 1'b1;
      if (n1 == ka) begin
         n1 = n1 + 1'b1;
      end
      return n1;
   endfunction

   // configuration
   logic [LEN_W-1:0] header_length_ff;
   logic [LEN_W-1:0] payload_limit_ff;
   logic [LEN_W-1:0] keepalive_length_ff;
   logic [NUM_W-1:0] keepalive_number_ff;
   logic [7:0]       loss_timeouts_ff;

   // event stage
   logic             in_valid_ff;
   op_type           in_op_ff;
   logic [LEN_W-1:0] in_len_ff;
   logic [NUM_W-1:0] in_num_ff;
   logic [SEL_W-1:0] in_sel_ff;

   // link state
   logic             service_ff, service_in;
   logic [7:0]       miss_count_ff, miss_count_in;
   logic [NUM_W-1:0] tx_number_ff, tx_number_in;
   logic [NUM_W-1:0] last_number_ff, last_number_in;
   logic             last_valid_ff, last_valid_in;
   logic [STAT_WIDTH-1:0] stat_ff [STAT_COUNT];
   logic [STAT_WIDTH-1:0] stat_in [STAT_COUNT];

   // result stage
   logic                  rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic                    advance;
   logic                    req_transfer;
   logic                    keep;
   logic                    malformed;
   logic [LEN_W-1:0]        pay_len;
   logic [NUM_W-1:0]        expect_num;
   logic [NUM_W-1:0]        delta;
   logic [STAT_WIDTH-1:0]   delta_ext;
   logic                    gap_hit;
   logic [7:0]              miss_inc;
   logic                    drop;
   logic                    deliver;
   logic [NUM_W-1:0]        stamp;
   logic [STAT_VALUE_W-1:0] value;
   logic [GAP_W-1:0]        gap;
   logic [STAT_WIDTH+STAT_VALUE_W-1:0] sel_wide;

   assign advance      = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready   = !in_valid_ff || advance;
   assign req_transfer = req_tvalid && req_tready;
   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_data_ff;
   assign csr_ready    = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         header_length_ff    <= RST_HEADER_LENGTH;
         payload_limit_ff    <= RST_PAYLOAD_LIMIT;
         keepalive_length_ff <= RST_KEEPALIVE_LENGTH;
         keepalive_number_ff <= RST_KEEPALIVE_NUMBER;
         loss_timeouts_ff    <= RST_LOSS_TIMEOUTS;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_HEADER_LENGTH:    header_length_ff    <= csr_data[LEN_W-1:0];
            CSR_PAYLOAD_LIMIT:    payload_limit_ff    <= csr_data[LEN_W-1:0];
            CSR_KEEPALIVE_LENGTH: keepalive_length_ff <= csr_data[LEN_W-1:0];
            CSR_KEEPALIVE_NUMBER: keepalive_number_ff <= csr_data[NUM_W-1:0];
            CSR_LOSS_TIMEOUTS:    loss_timeouts_ff    <= csr_data[7:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_transfer) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_transfer) begin
         in_op_ff  <= op_type'(req_tuser);
         in_len_ff <= req_tdata[LEN_W-1:0];
         in_num_ff <= req_tdata[LEN_W+NUM_W-1:LEN_W];
         in_sel_ff <= req_tdata[REQ_FIELDS_W-1:LEN_W+NUM_W];
      end
   end

   always_comb begin
      keep       = (in_len_ff == keepalive_length_ff) && (in_num_ff == keepalive_number_ff);
      pay_len    = in_len_ff - header_length_ff;
      malformed  = (in_len_ff < header_length_ff) || (pay_len > payload_limit_ff) ||
                   (!keep && (in_len_ff == header_length_ff));
      expect_num = next_number(last_number_ff, keepalive_number_ff);
      delta      = in_num_ff - expect_num;
      delta_ext  = STAT_WIDTH'(delta);
      // backward or repeated numbers have the top bit set
      gap_hit    = last_valid_ff && (delta != '0) && !delta[NUM_W-1];
      miss_inc   = miss_count_ff + 8'd1;
      sel_wide   = {{STAT_VALUE_W{1'b0}}, stat_ff[in_sel_ff]};

      service_in     = service_ff;
      miss_count_in  = miss_count_ff;
      tx_number_in   = tx_number_ff;
      last_number_in = last_number_ff;
      last_valid_in  = last_valid_ff;
      for (int i = 0; i < STAT_COUNT; i++) begin
         stat_in[i] = stat_ff[i];
      end
      drop    = 1'b0;
      deliver = 1'b0;
      stamp   = '0;
      value   = '0;
      gap     = '0;

      if (advance) begin
         case (in_op_ff)
            OP_RX_GOOD: begin
               if (!malformed) begin
                  miss_count_in = '0;
                  service_in    = 1'b1;
                  if (!keep) begin
                     deliver = 1'b1;
                     if (gap_hit) begin
                        gap = delta[GAP_W-1:0];
                        stat_in[IDX_LOST] = stat_ff[IDX_LOST] + delta_ext;
                        if (delta == 16'd1) begin
                           stat_in[IDX_BURST_1] = stat_ff[IDX_BURST_1] + 1'b1;
                        end else if (delta == 16'd2) begin
                           stat_in[IDX_BURST_2] = stat_ff[IDX_BURST_2] + 1'b1;
                        end else if (delta <= 16'd4) begin
                           stat_in[IDX_BURST_3_4] = stat_ff[IDX_BURST_3_4] + 1'b1;
                        end else begin
                           stat_in[IDX_BURST_5UP] = stat_ff[IDX_BURST_5UP] + 1'b1;
                        end
                        if (delta_ext > stat_ff[IDX_MAX]) begin
                           stat_in[IDX_MAX] = delta_ext;
                        end
                     end
                     last_number_in = in_num_ff;
                     last_valid_in  = 1'b1;
                  end
               end
            end
            OP_RX_BAD: begin
               miss_count_in = '0;
            end
            OP_RX_INCOMPLETE: begin
               stat_in[IDX_INCOMPLETE] = stat_ff[IDX_INCOMPLETE] + 1'b1;
               miss_count_in = '0;
            end
            OP_LISTEN_TIMEOUT: begin
               if (service_ff) begin
                  miss_count_in = miss_inc;
                  if (miss_inc >= loss_timeouts_ff) begin
                     drop = 1'b1;
                  end
               end
            end
            OP_TX_FAIL: begin
               stat_in[IDX_TXFAIL] = stat_ff[IDX_TXFAIL] + 1'b1;
               drop = 1'b1;
            end
            OP_TX_STAMP: begin
               stamp        = tx_number_ff;
               tx_number_in = next_number(tx_number_ff, keepalive_number_ff);
            end
            OP_READ_STAT: begin
               if (in_sel_ff < STAT_COUNT) begin
                  value = sel_wide[STAT_VALUE_W-1:0];
               end
            end
            default: ;
         endcase
      end

      if (drop) begin
         if (service_ff) begin
            stat_in[IDX_OUTAGE] = stat_ff[IDX_OUTAGE] + 1'b1;
         end
         service_in    = 1'b0;
         miss_count_in = '0;
         last_valid_in = 1'b0;
      end

      rsp_data_in = {{(RSP_DATA_W-RSP_FIELDS_W){1'b0}}, gap, value, stamp, deliver, service_in};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         service_ff     <= 1'b0;
         miss_count_ff  <= '0;
         tx_number_ff   <= '0;
         last_number_ff <= '0;
         last_valid_ff  <= 1'b0;
         for (int i = 0; i < STAT_COUNT; i++) begin
            stat_ff[i] <= '0;
         end
      end else begin
         service_ff     <= service_in;
         miss_count_ff  <= miss_count_in;
         tx_number_ff   <= tx_number_in;
         last_number_ff <= last_number_in;
         last_valid_ff  <= last_valid_in;
         for (int i = 0; i < STAT_COUNT; i++) begin
            stat_ff[i] <= stat_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

[sv/rlsm_checker.sv]
// port-level checks for the radio link service monitor, bound to the top level
// depends on rlsm_pkg and radio_link_service_monitor
module rlsm_port_checks (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_tvalid,
   input logic                                req_tready,
   // packet_length, packet_number, stat_select, zero pad
   input logic [rlsm_pkg::REQ_DATA_W-1:0]     req_tdata,
   // operation
   input logic [rlsm_pkg::OP_W-1:0]           req_tuser,
   input logic                                rsp_tvalid,
   input logic                                rsp_tready,
   // in_service, deliver_frame, stamp_number, stat_value, gap_found, zero pad
   input logic [rlsm_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input logic                                csr_valid,
   input logic                                csr_ready,
   input logic [rlsm_pkg::CSR_INDEX_W-1:0]    csr_index,
   input logic [rlsm_pkg::CSR_DATA_W-1:0]     csr_data
);
   import rlsm_pkg::*;

   localparam int GAP_LO = 2 + NUM_W + STAT_VALUE_W;

   // stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // no result right after reset
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // an empty result side never blocks new events
   assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("event stage blocked with empty result stage");

   // a gap is only reported on a delivered frame with the link in service
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[GAP_LO+GAP_W-1:GAP_LO] != '0) |-> rsp_tdata[1] && rsp_tdata[0])
      else $error("gap without delivered frame");

endmodule

bind radio_link_service_monitor rlsm_port_checks u_rlsm_port_checks (.*);
